/* src/bni_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bni_pkg
// Shared types and constants for the batch normalization block.
// ----------------------------------------------------------------------------
package bni_pkg;

  localparam int unsigned DefMaxChannels = 1024;
  localparam int unsigned DefMaxPlane    = 65536;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdData = 1'b1;

  localparam logic RegPlaneSize    = 1'b0;
  localparam logic RegChannelCount = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQRT = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_STORE = 5'b01000,
    ST_DATA = 5'b10000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic start_load;  // latch load operands, set up root
    logic sqrt_step;   // one root iteration
    logic div_init;    // set up divider
    logic div_step;    // one divide iteration
    logic store;       // write tables
    logic start_data;  // issue a data item into the pipeline
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic pipe_busy;   // data pipeline can not take an item
  } stat_t;

endpackage
`default_nettype wire

/* src/bni_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bni_ctrl
// Controller: decodes items and sequences the root and divide for loads.
// ----------------------------------------------------------------------------
module bni_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_cmd_i,
  output logic               in_ready_o,
  input  var  bni_pkg::stat_t stat_i,
  output bni_pkg::ctrl_t     ctrl_o
);
  import bni_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE) && !stat_i.pipe_busy;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd_i == CmdLoad) begin
            ctrl_o.start_load = 1'b1;
            state_d = ST_SQRT;
          end else begin
            ctrl_o.start_data = 1'b1;
          end
        end
      end
      ST_SQRT: begin
        if (stat_i.sqrt_done) begin
          ctrl_o.div_init = 1'b1;
          state_d = ST_DIV;
        end else begin
          ctrl_o.sqrt_step = 1'b1;
        end
      end
      ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = ST_STORE;
        end else begin
          ctrl_o.div_step = 1'b1;
        end
      end
      ST_STORE: begin
        ctrl_o.store = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

endmodule
`default_nettype wire

/* src/bni_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bni_datapath
// Root, divider, parameter tables, position counters and the data pipeline.
// ----------------------------------------------------------------------------
module bni_datapath #(
  parameter int unsigned MaxChannels = bni_pkg::DefMaxChannels,
  parameter int unsigned MaxPlane    = bni_pkg::DefMaxPlane
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  var  bni_pkg::ctrl_t ctrl_i,
  output bni_pkg::stat_t     stat_o,
  input  wire logic [9:0]    load_channel_i,
  input  wire logic signed [15:0] sample_i,
  input  wire logic signed [15:0] mean_i,
  input  wire logic [23:0]   variance_i,
  input  wire logic signed [15:0] gamma_i,
  input  wire logic signed [15:0] beta_i,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_index_i,
  input  wire logic [16:0]   cfg_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic signed [15:0] out_normalized_o,
  output logic [9:0]         out_channel_o,
  output logic               out_last_o
);
  import bni_pkg::*;

  localparam int unsigned AW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int unsigned ChCap = (MaxChannels < 1024) ? MaxChannels : 1024;
  localparam int unsigned PlCap = (MaxPlane < 65536) ? MaxPlane : 65536;
  localparam logic [10:0] ChCapV = 11'(ChCap);
  localparam logic [16:0] PlCapV = 17'(PlCap);

  // ---------------- configuration ----------------
  logic [16:0] plane_size_q;
  logic [10:0] channel_count_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_size_q    <= 17'd1;
      channel_count_q <= 11'd1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegPlaneSize) plane_size_q <= cfg_data_i;
      else channel_count_q <= cfg_data_i[10:0];
    end
  end

  logic [16:0] pl_lim;
  logic [10:0] ch_lim;
  always_comb begin
    pl_lim = plane_size_q;
    if (pl_lim > PlCapV) pl_lim = PlCapV;
    if (pl_lim == '0) pl_lim = 17'd1;
    ch_lim = channel_count_q;
    if (ch_lim > ChCapV) ch_lim = ChCapV;
    if (ch_lim == '0) ch_lim = 11'd1;
  end

  // ---------------- load path: root, 21 steps over 42-bit radicand ----------
  logic [41:0] rad_q;      // remainder
  logic [41:0] root_q;
  logic [41:0] bit_q;
  logic [15:0] gmag_q;
  logic        gneg_q;
  logic [9:0]  lch_q;
  logic [15:0] lmean_q, lbeta_q;

  logic [41:0] trial;
  assign trial = root_q + bit_q;

  // divider: quotient of (mag << 24) by s, plus rounding, restoring
  logic [39:0] dividend_q;   // mag<<24 + s>>1
  logic [21:0] divisor_q;    // s <= 2^20 + small
  logic [22:0] rem_q;
  logic [39:0] quo_q;
  logic [5:0]  dcnt_q;
  logic [22:0] rem_sh;
  assign rem_sh = {rem_q[21:0], dividend_q[39]};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start_load) begin
      rad_q   <= {2'b00, 24'(variance_i) + 24'd0, 16'd0} + 42'h10000;
      root_q  <= '0;
      bit_q   <= 42'h1 << 40;
      gneg_q  <= gamma_i[15];
      gmag_q  <= gamma_i[15] ? 16'(-gamma_i) : 16'(gamma_i);
      lch_q   <= load_channel_i;
      lmean_q <= mean_i;
      lbeta_q <= beta_i;
    end else if (ctrl_i.sqrt_step) begin
      if (rad_q >= trial) begin
        rad_q  <= rad_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (ctrl_i.div_init) begin
      dividend_q <= {gmag_q, 24'd0} + 40'(root_q[21:1]);
      divisor_q  <= root_q[21:0];
      rem_q      <= '0;
      quo_q      <= '0;
      dcnt_q     <= 6'd40;
    end else if (ctrl_i.div_step) begin
      dividend_q <= {dividend_q[38:0], 1'b0};
      if (rem_sh >= {1'b0, divisor_q}) begin
        rem_q <= rem_sh - {1'b0, divisor_q};
        quo_q <= {quo_q[38:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[38:0], 1'b0};
      end
      dcnt_q <= dcnt_q - 6'd1;
    end
  end
  assign stat_o.sqrt_done = (bit_q == '0);
  assign stat_o.div_done  = (dcnt_q == '0);

  logic [31:0] scale_new;
  assign scale_new = gneg_q ? (32'd0 - quo_q[31:0]) : quo_q[31:0];

  // ---------------- tables ----------------
  logic [31:0] scale_mem [MaxChannels];
  logic [15:0] mean_mem  [MaxChannels];
  logic [15:0] beta_mem  [MaxChannels];
  logic        wr_en;
  assign wr_en = ctrl_i.store && (32'(lch_q) < MaxChannels);

  // ---------------- counters ----------------
  logic [9:0]  chan_q;
  logic [15:0] pos_q;
  logic [9:0]  ch_cur;
  logic        pl_end, ch_end;
  always_comb begin
    ch_cur = ({1'b0, chan_q} >= ch_lim) ? 10'd0 : chan_q;
    pl_end = (17'(pos_q) + 17'd1 >= pl_lim);
    ch_end = (11'(ch_cur) + 11'd1 >= ch_lim);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= '0;
      pos_q  <= '0;
    end else if (ctrl_i.start_data) begin
      if (pl_end) begin
        pos_q  <= '0;
        chan_q <= ch_end ? 10'd0 : ch_cur + 10'd1;
      end else begin
        pos_q  <= pos_q + 16'd1;
        chan_q <= ch_cur;
      end
    end
  end

  // ---------------- data pipeline ----------------
  // s1: table read; s2: subtract; s3: multiply; s4: round, add, saturate
  logic        v1_q, v2_q, v3_q, v4_q;
  logic [31:0] sc1_q;
  logic [15:0] mn1_q, bt1_q;
  logic signed [15:0] x1_q;
  logic [9:0]  c1_q, c2_q, c3_q;
  logic        l1_q, l2_q, l3_q;
  logic signed [31:0] sc2_q;
  logic signed [16:0] d2_q;
  logic signed [15:0] bt2_q, bt3_q;
  logic signed [48:0] p3_q;
  logic        adv;

  assign adv = !v4_q || out_ready_i;
  assign stat_o.pipe_busy = !adv || v1_q || v2_q || v3_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      scale_mem[lch_q[AW-1:0]] <= scale_new;
      mean_mem[lch_q[AW-1:0]]  <= lmean_q;
      beta_mem[lch_q[AW-1:0]]  <= lbeta_q;
    end
    if (ctrl_i.start_data) begin
      sc1_q <= scale_mem[ch_cur[AW-1:0]];
      mn1_q <= mean_mem[ch_cur[AW-1:0]];
      bt1_q <= beta_mem[ch_cur[AW-1:0]];
      x1_q  <= sample_i;
      c1_q  <= ch_cur;
      l1_q  <= ch_end && pl_end;
    end
    if (v1_q) begin
      sc2_q <= sc1_q;
      d2_q  <= 17'(x1_q) - 17'(signed'(mn1_q));
      bt2_q <= bt1_q;
      c2_q  <= c1_q;
      l2_q  <= l1_q;
    end
    if (v2_q) begin
      p3_q  <= 49'(sc2_q) * 49'(d2_q);
      bt3_q <= bt2_q;
      c3_q  <= c2_q;
      l3_q  <= l2_q;
    end
  end

  logic signed [49:0] rnd;
  logic signed [34:0] yv;
  logic signed [15:0] ysat;
  always_comb begin
    rnd = 50'(p3_q) + 50'sd32768;
    yv  = 35'(rnd >>> 16) + 35'(bt3_q);
    if (yv > 35'sd32767) ysat = 16'sh7fff;
    else if (yv < -35'sd32768) ysat = 16'sh8000;
    else ysat = yv[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.start_data;
      v2_q <= v1_q;
      if (adv) begin
        v3_q <= v2_q;
        v4_q <= v3_q;
      end else if (v2_q) begin
        v3_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v3_q) begin
      out_normalized_o <= ysat;
      out_channel_o    <= c3_q;
      out_last_o       <= l3_q;
    end
  end
  assign out_valid_o = v4_q;

endmodule
`default_nettype wire

/* src/batch_norm_inference.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// batch_norm_inference
// Per-channel batch normalization: y = scale*(x-mean)+beta, Q8.8 saturated.
// ----------------------------------------------------------------------------
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata, tuser = command
// m_axis    out  m_axis_tvalid/tready      tdata, tlast = last
// cfg       in   cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
// A data item passes the table read, subtract, multiply and round stages;
// the pipeline holds one item at a time, so a new data item is accepted
// only once the last one has reached the result register. A load item runs
// 21 root steps and 40 divide steps in the iterative units. Reset clears
// the counters and sets both registers to one; tables are undefined until
// loaded. Output stalls hold the result register and block new items.
// ----------------------------------------------------------------------------
module batch_norm_inference #(
  parameter int unsigned MaxChannels = bni_pkg::DefMaxChannels,
  parameter int unsigned MaxPlane    = bni_pkg::DefMaxPlane
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // load_channel[9:0], sample[25:10], mean_value[41:26], variance_value[65:42],
  // gamma_value[81:66], beta_value[97:82], zero pad [103:98]
  input  wire logic [103:0] s_axis_tdata,
  // command[0]
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // normalized[15:0], out_channel[25:16], zero pad [31:26]
  output logic [31:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [16:0] cfg_data_i
);
  import bni_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic signed [15:0] norm;
  logic [9:0]  och;

  assign cfg_ready_o = 1'b1;

  bni_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  bni_datapath #(
    .MaxChannels (MaxChannels),
    .MaxPlane    (MaxPlane)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .load_channel_i   (s_axis_tdata[9:0]),
    .sample_i         (s_axis_tdata[25:10]),
    .mean_i           (s_axis_tdata[41:26]),
    .variance_i       (s_axis_tdata[65:42]),
    .gamma_i          (s_axis_tdata[81:66]),
    .beta_i           (s_axis_tdata[97:82]),
    .cfg_we_i         (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_normalized_o (norm),
    .out_channel_o    (och),
    .out_last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, och, norm};

endmodule
`default_nettype wire

/* tb/sv/bni_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bni_checker
// Watches the item, result and register channels of batch_norm_inference,
// predicts every normalized result from its own copy of the tables, counters
// and registers, and compares results field by field in order.
// ----------------------------------------------------------------------------
module bni_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [103:0] s_axis_tdata,
  input  wire logic         s_axis_tuser,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [31:0]  m_axis_tdata,
  input  wire logic         m_axis_tlast,
  input  wire logic         cfg_valid_i,
  input  wire logic         cfg_ready_o,
  input  wire logic         cfg_index_i,
  input  wire logic [16:0]  cfg_data_i,
  output int                errors_o,
  output int                pending_o
);
  import bni_pkg::*;

  typedef struct packed {
    logic [15:0] normalized;
    logic [9:0]  channel;
    logic        last;
  } norm_result_t;

  logic [31:0] scale_mem [1024];
  logic [15:0] mean_mem  [1024];
  logic [15:0] beta_mem  [1024];
  int unsigned chan_cnt, pos_cnt;
  logic [16:0] plane_reg;
  logic [10:0] chans_reg;
  norm_result_t expected_q [$];

  assign pending_o = expected_q.size();

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // gamma / sqrt(var + eps) in Q16.16, rounded half away from zero
  function automatic logic [31:0] channel_scale(logic [23:0] variance, logic signed [15:0] gamma);
    longint unsigned root, mag, quo;
    root = int_sqrt((longint'(variance) + 1) << 16);
    mag  = (gamma < 0) ? longint'(-longint'(gamma)) : longint'(gamma);
    quo  = ((mag << 24) + (root >> 1)) / root;
    return (gamma < 0) ? 32'(-quo) : 32'(quo);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    norm_result_t  res, want;
    int unsigned   ch_lim, pl_lim, ch;
    logic [9:0]    lc;
    longint        diff, prod, y;
    if (!rst_ni) begin
      chan_cnt  = 0;
      pos_cnt   = 0;
      plane_reg = 17'd1;
      chans_reg = 11'd1;
      errors_o  = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegPlaneSize) plane_reg = cfg_data_i;
        else chans_reg = cfg_data_i[10:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == CmdLoad) begin
          lc = s_axis_tdata[9:0];
          scale_mem[lc] = channel_scale(s_axis_tdata[65:42], s_axis_tdata[81:66]);
          mean_mem[lc]  = s_axis_tdata[41:26];
          beta_mem[lc]  = s_axis_tdata[97:82];
        end else begin
          ch_lim = (chans_reg == 0) ? 1 : (chans_reg > 1024 ? 1024 : chans_reg);
          pl_lim = (plane_reg == 0) ? 1 : (plane_reg > 65536 ? 65536 : plane_reg);
          ch = (chan_cnt >= ch_lim) ? 0 : chan_cnt;
          diff = longint'($signed(s_axis_tdata[25:10])) - longint'($signed(mean_mem[ch]));
          prod = longint'($signed(scale_mem[ch])) * diff;
          y = ((prod + 32768) >>> 16) + longint'($signed(beta_mem[ch]));
          if (y > 32767) y = 32767;
          if (y < -32768) y = -32768;
          res.normalized = y[15:0];
          res.channel    = ch[9:0];
          res.last       = (ch + 1 >= ch_lim) && (pos_cnt + 1 >= pl_lim);
          expected_q.push_back(res);
          if (pos_cnt + 1 >= pl_lim) begin
            pos_cnt  = 0;
            chan_cnt = (ch + 1 >= ch_lim) ? 0 : ch + 1;
          end else begin
            pos_cnt  = pos_cnt + 1;
            chan_cnt = ch;
          end
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, normalized", $signed(m_axis_tdata[15:0]), 0);
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata[15:0] != want.normalized)
            report_mismatch("normalized", $signed(m_axis_tdata[15:0]), $signed(want.normalized));
          if (m_axis_tdata[25:16] != want.channel)
            report_mismatch("out_channel", m_axis_tdata[25:16], want.channel);
          if (m_axis_tlast != want.last)
            report_mismatch("last", m_axis_tlast, want.last);
        end
      end
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for batch_norm_inference: channel loads and data planes under
// several register settings, random idling on both streams, a long output
// stall, and a pass or fail verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb;
  import bni_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 80;   // lets a load in flight finish

  logic         clk_i, rst_ni;
  logic         s_valid, s_user, m_ready, cfg_valid, cfg_index;
  logic [103:0] s_data;
  logic [16:0]  cfg_data;
  wire          s_ready, m_valid, m_last, cfg_ready;
  wire  [31:0]  m_data;
  int           errors, pending;
  bit           tx_calm, rx_calm, hold_now;
  bit           loaded [1024];

  batch_norm_inference dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
    .s_axis_tdata(s_data), .s_axis_tuser(s_user),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_data), .m_axis_tlast(m_last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  bni_checker chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
    .s_axis_tdata(s_data), .s_axis_tuser(s_user),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_data), .m_axis_tlast(m_last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stalls, one long hold-off
  initial begin
    int cyc;
    bit held;
    cyc  = 0;
    held = 0;
    m_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      rx_calm = (cyc >= 3000 && cyc < 4500);
      if (hold_now && !held) begin
        held = 1;
        m_ready <= 1'b0;
        repeat (300) @(negedge clk_i);
      end
      m_ready <= rx_calm || ($urandom_range(99) >= 28);
    end
  end

  // stall watchdog
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
        idle = 0;
      else if (++idle >= WatchdogLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_item(logic cmd, logic [103:0] payload);
    if (!tx_calm)
      while ($urandom_range(99) < 28) begin
        s_valid <= 1'b0;
        @(negedge clk_i);
      end
    s_valid <= 1'b1;
    s_user  <= cmd;
    s_data  <= payload;
    do @(posedge clk_i); while (!s_ready);
    @(negedge clk_i);
  endtask

  task automatic load_channel(logic [9:0] ch, logic [15:0] mean, logic [23:0] variance,
                              logic [15:0] gamma, logic [15:0] beta);
    loaded[ch] = 1;
    send_item(CmdLoad, {6'd0, beta, gamma, variance, mean, 16'($urandom), ch});
  endtask

  task automatic send_sample(logic [15:0] x);
    send_item(CmdData, {6'd0, 72'({$urandom, $urandom, $urandom}), x, 10'($urandom)});
  endtask

  task automatic random_load(logic [9:0] ch);
    load_channel(ch, 16'($urandom), 24'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // wait for all results, then let any load in flight finish
  task automatic drain;
    s_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [16:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_layer(logic [16:0] plane, logic [10:0] chans, int samples);
    int ch_lim, pl_lim, start, reach;
    drain();
    write_reg(RegPlaneSize, plane);
    write_reg(RegChannelCount, chans);
    ch_lim = (chans == 0) ? 1 : (chans > 1024 ? 1024 : chans);
    pl_lim = (plane == 0) ? 1 : (plane > 65536 ? 65536 : plane);
    // counters carry over, so only the channels this layer can reach get loaded
    start = (chk.chan_cnt >= ch_lim) ? 0 : int'(chk.chan_cnt);
    reach = samples / pl_lim + 3;
    if (reach > ch_lim) reach = ch_lim;
    for (int k = 0; k < reach; k++)
      if (!loaded[(start + k) % ch_lim]) random_load(10'((start + k) % ch_lim));
    for (int i = 0; i < samples; i++) begin
      tx_calm = (i >= 20 && i < 60 && samples >= 80);
      if (i == 30 && samples >= 80) hold_now = 1;
      if ($urandom_range(99) < 8) random_load(10'($urandom_range(1023)));
      send_sample(16'($urandom));
    end
    tx_calm = 0;
  endtask

  initial begin
    logic [15:0] edge_samples [6];
    edge_samples = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5A5A};
    s_valid = 1'b0; s_user = 1'b0; s_data = '0;
    cfg_valid = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    tx_calm = 0; hold_now = 0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extreme parameters and samples, 2 x 3 layer
    write_reg(RegPlaneSize, 17'd2);
    write_reg(RegChannelCount, 11'd3);
    load_channel(10'd0, 16'h8000, 24'h000000, 16'h7FFF, 16'h7FFF);
    load_channel(10'd1, 16'h7FFF, 24'hFFFFFF, 16'h8000, 16'h8000);
    load_channel(10'd2, 16'h0100, 24'h012345, 16'h0000, 16'h0080);
    load_channel(10'd1023, 16'hFFFF, 24'h000001, 16'hFFFF, 16'h0001);
    for (int i = 0; i < 12; i++) send_sample(edge_samples[i % 6]);
    load_channel(10'd0, 16'h0000, 24'h000000, 16'h8000, 16'h0000);
    for (int i = 0; i < 6; i++) send_sample(edge_samples[i]);

    run_layer(17'd3, 11'd2, 90);
    run_layer(17'd0, 11'd0, 30);           // both clamp up to one
    run_layer(17'd131071, 11'd2047, 40);   // both clamp to max
    run_layer(17'd65536, 11'd1, 60);
    run_layer(17'd1, 11'd1024, 40);
    repeat (4) run_layer(17'($urandom_range(1, 8)), 11'($urandom_range(1, 6)), 30);

    drain();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
